// ===== rtl/core/error_norm_accumulator_top_macros.svh =====
// Assertion macros shared by the error norm accumulator RTL.
`ifndef ERROR_NORM_ACCUMULATOR_TOP_MACROS_SVH
`define ERROR_NORM_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ENA_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ENA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ena_pkg.sv =====
// Package: widths and control/status types of the error norm accumulator.
package ena_pkg;

    localparam int unsigned SAMPLE_W     = 24;
    localparam int unsigned NORM_W       = 24;
    localparam int unsigned PAIR_COUNT_W = 17;
    localparam int unsigned ABS_SUM_W    = 41;
    localparam int unsigned SQ_W         = 48;
    localparam int unsigned SQ_SUM_W     = 64;
    localparam int unsigned ROOT_W       = SQ_SUM_W / 2;
    localparam int unsigned MAX_PAIRS_DEF = 65536;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic div_start;   // launch the shared divider
        logic div_sq;      // 1: divide the squared sum, 0: the absolute sum
        logic sqrt_start;  // launch the root unit on the divider quotient
        logic load;        // load the result register and clear the set
    } ena_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pipe_busy;   // accumulation stages still hold a pair
        logic div_busy;
        logic div_done;
        logic sqrt_done;
        logic out_free;    // result register empty
    } ena_status_t;

endpackage

// ===== rtl/core/ena_pair_if.sv =====
// Interface: input channel carrying one sample pair per transaction.
interface ena_pair_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ena_pkg::SAMPLE_W-1:0]     computed_sample;
    logic signed [ena_pkg::SAMPLE_W-1:0]     reference_sample;
    logic                                    last_pair;

    modport source
    (
        output valid, computed_sample, reference_sample, last_pair,
        input  ready
    );

    modport sink
    (
        input  valid, computed_sample, reference_sample, last_pair,
        output ready
    );
endinterface

// ===== rtl/core/ena_norm_if.sv =====
// Interface: output channel carrying the error norms of one set per transaction.
interface ena_norm_if;
    logic                                valid;
    logic                                ready;
    logic [ena_pkg::NORM_W-1:0]          mean_abs_error;
    logic [ena_pkg::NORM_W-1:0]          rms_error;
    logic [ena_pkg::NORM_W-1:0]          max_abs_error;
    logic [ena_pkg::PAIR_COUNT_W-1:0]    pair_count;
    logic                                overflow;

    modport source
    (
        output valid, mean_abs_error, rms_error, max_abs_error, pair_count, overflow,
        input  ready
    );

    modport sink
    (
        input  valid, mean_abs_error, rms_error, max_abs_error, pair_count, overflow,
        output ready
    );
endinterface

// ===== rtl/core/error_norm_accumulator_top.sv =====
// Top level: L1, L2 and Linf error norms over a stream of sample pairs.
//
// Each input transaction carries a computed and a reference sample (signed
// Q8.16) and a last-pair flag. While a set is being gathered the block takes
// one pair per clock: the difference, its magnitude, the square and the
// saturating 64-bit sum run through three register stages. Once the pair
// marked last is accepted, ready drops and the block finishes the set: it
// waits for the stages to empty, runs the shared bit-serial divider twice
// (absolute sum over count, then squared sum over count), takes an integer
// square root of the second quotient and then loads the result register.
// Ready rises again after that load, which waits for the two divider runs,
// the root unit and any previous result still in the result register. The
// result register parts the two channels: pairs of the next set are taken
// while the previous result waits to be collected. Mean and RMS error
// truncate and clamp to 2^24-1. Pairs arriving when the count already
// equals MAX_PAIRS are dropped from every sum and raise overflow, as does a
// squared sum that saturates. All accumulators clear when the result is
// loaded.
`include "error_norm_accumulator_top_macros.svh"

module error_norm_accumulator_top #(
    parameter int unsigned MAX_PAIRS = ena_pkg::MAX_PAIRS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ena_pair_if.sink   pairs,
    ena_norm_if.source norms
);
    logic                 accept;
    logic                 ready;
    ena_pkg::ena_cmd_t    cmd;
    ena_pkg::ena_status_t st;

    // a transaction completes when both sides agree
    assign accept      = pairs.valid && ready;
    assign pairs.ready = ready;

    ena_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .last_pair (pairs.last_pair),
        .st        (st),
        .ready     (ready),
        .cmd       (cmd)
    );

    ena_datapath #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .computed_sample  (pairs.computed_sample),
        .reference_sample (pairs.reference_sample),
        .cmd              (cmd),
        .st               (st),
        .norm_ready       (norms.ready),
        .norm_valid       (norms.valid),
        .mean_abs_error   (norms.mean_abs_error),
        .rms_error        (norms.rms_error),
        .max_abs_error    (norms.max_abs_error),
        .pair_count       (norms.pair_count),
        .overflow         (norms.overflow)
    );

    // hold off new pairs once the last pair of a set has gone in
    `ENA_ASSERT_NEXT(a_last_drops_ready, clk, rst_n, accept && pairs.last_pair, !pairs.ready, "ready stayed high after last pair")
    // never gather pairs while the divider is still working on a set
    `ENA_ASSERT_SAME(a_no_accept_in_div, clk, rst_n, pairs.ready, !st.div_busy, "ready high during divide")
    // a result appears only from a load command
    `ENA_ASSERT_SAME(a_valid_from_load, clk, rst_n, $rose(norms.valid), $past(cmd.load), "result valid without load")
endmodule

// ===== rtl/core/ena_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ena_div #(
    parameter int unsigned DVSR_W = 17
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ena_pkg::SQ_SUM_W-1:0]      dividend,
    input  logic [DVSR_W-1:0]                 divisor,
    output logic [ena_pkg::SQ_SUM_W-1:0]      quotient,
    output logic                              busy,
    output logic                              done
);
    localparam int unsigned DVD_W = ena_pkg::SQ_SUM_W;
    localparam int unsigned CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVSR_W:0]   shifted;
    logic [DVSR_W+1:0] trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        trial     = {1'b0, shifted} - {2'b00, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = CNT_W'(DVD_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial subtraction unless it borrows
            if (!trial[DVSR_W+1])
            begin
                rem_next = trial[DVSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - CNT_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
endmodule

// ===== rtl/core/ena_isqrt.sv =====
// Iterative integer square root: one result bit per cycle.
module ena_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ena_pkg::SQ_SUM_W-1:0]    radicand,
    output logic [ena_pkg::ROOT_W-1:0]      root,
    output logic                            done
);
    localparam int unsigned W     = ena_pkg::SQ_SUM_W;
    localparam int unsigned STEPS = ena_pkg::ROOT_W;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic [W-1:0]     v_reg, v_next;
    logic [W-1:0]     res_reg, res_next;
    logic [W-1:0]     bit_reg, bit_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W-1:0]     trial;

    always_comb
    begin
        trial     = res_reg + bit_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(W-2){1'b0}}};
            step_next = CNT_W'(STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            step_next = step_reg - CNT_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root = res_reg[STEPS-1:0];
    assign done = done_reg;
endmodule

// ===== rtl/core/ena_datapath.sv =====
// Datapath: accumulation stages, shared divider, root unit and result register.
module ena_datapath #(
    parameter int unsigned MAX_PAIRS = ena_pkg::MAX_PAIRS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]   computed_sample,
    input  logic signed [ena_pkg::SAMPLE_W-1:0]   reference_sample,
    input  ena_pkg::ena_cmd_t                     cmd,
    output ena_pkg::ena_status_t                  st,
    input  logic                                  norm_ready,
    output logic                                  norm_valid,
    output logic [ena_pkg::NORM_W-1:0]            mean_abs_error,
    output logic [ena_pkg::NORM_W-1:0]            rms_error,
    output logic [ena_pkg::NORM_W-1:0]            max_abs_error,
    output logic [ena_pkg::PAIR_COUNT_W-1:0]      pair_count,
    output logic                                  overflow
);
    localparam int unsigned SW    = ena_pkg::SAMPLE_W;
    localparam int unsigned NW    = ena_pkg::NORM_W;
    localparam int unsigned AW    = ena_pkg::ABS_SUM_W;
    localparam int unsigned QW    = ena_pkg::SQ_W;
    localparam int unsigned SSW   = ena_pkg::SQ_SUM_W;
    localparam int unsigned RW    = ena_pkg::ROOT_W;
    localparam int unsigned CNT_W = $clog2(MAX_PAIRS + 1);

    // accumulation state
    logic [CNT_W-1:0] count_reg;
    logic             sat_reg;
    logic [AW-1:0]    abs_sum_reg;
    logic [SSW-1:0]   sq_sum_reg;
    logic [SW-1:0]    max_reg;
    // stage registers
    logic             v1_reg, v2_reg;
    logic [SW-1:0]    abs_reg;
    logic [QW-1:0]    sq_reg;

    logic [SW:0]      diff;
    logic [SW:0]      mag;
    logic             count_full;
    logic [SSW:0]     sq_total;
    logic [QW-1:0]    prod;

    logic [SSW-1:0]   dividend;
    logic [SSW-1:0]   quotient;
    logic             div_busy, div_done;
    logic [RW-1:0]    root;
    logic             sqrt_done;
    logic [NW-1:0]    mean_reg;

    logic             out_valid_reg;
    logic [NW-1:0]    out_mean_reg, out_rms_reg, out_max_reg;
    logic [ena_pkg::PAIR_COUNT_W-1:0] out_count_reg;
    logic             out_ovf_reg;
    logic [NW-1:0]    mean_final, rms_final;

    assign diff       = (SW+1)'(computed_sample) - (SW+1)'(reference_sample);
    assign mag        = diff[SW] ? -diff : diff;
    assign count_full = (count_reg >= CNT_W'(MAX_PAIRS));
    assign prod       = abs_reg * abs_reg;
    assign sq_total   = {1'b0, sq_sum_reg} + (SSW+1)'(sq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sat_reg     <= 1'b0;
            abs_sum_reg <= '0;
            sq_sum_reg  <= '0;
            max_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else if (cmd.load)
        begin
            count_reg   <= '0;
            sat_reg     <= 1'b0;
            abs_sum_reg <= '0;
            sq_sum_reg  <= '0;
            max_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            // stage 0: count the pair, or drop it once the set is full
            v1_reg <= 1'b0;
            if (accept)
            begin
                if (count_full)
                begin
                    sat_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    v1_reg    <= 1'b1;
                end
            end
            // stage 1: absolute sum and maximum
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                abs_sum_reg <= abs_sum_reg + AW'(abs_reg);
                if (abs_reg > max_reg)
                begin
                    max_reg <= abs_reg;
                end
            end
            // stage 2: saturating squared sum
            if (v2_reg)
            begin
                if (sq_total[SSW])
                begin
                    sq_sum_reg <= '1;
                    sat_reg    <= 1'b1;
                end
                else
                begin
                    sq_sum_reg <= sq_total[SSW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg <= mag[SW-1:0];
        sq_reg  <= prod;
    end

    assign dividend = cmd.div_sq ? sq_sum_reg : SSW'(abs_sum_reg);

    ena_div #(
        .DVSR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    ena_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (quotient),
        .root     (root),
        .done     (sqrt_done)
    );

    // capture the clamped mean when the first divide finishes
    always_ff @(posedge clk)
    begin
        if (div_done && !cmd.div_sq)
        begin
            mean_reg <= (quotient[SSW-1:NW] != '0) ? '1 : quotient[NW-1:0];
        end
    end

    assign mean_final = (count_reg == '0) ? '0 : mean_reg;
    assign rms_final  = (count_reg == '0) ? '0 :
                        ((root[RW-1:NW] != '0) ? '1 : root[NW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (norm_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_mean_reg  <= mean_final;
            out_rms_reg   <= rms_final;
            out_max_reg   <= max_reg;
            out_count_reg <= ena_pkg::PAIR_COUNT_W'(count_reg);
            out_ovf_reg   <= sat_reg;
        end
    end

    always_comb
    begin
        st           = '0;
        st.pipe_busy = v1_reg | v2_reg;
        st.div_busy  = div_busy;
        st.div_done  = div_done;
        st.sqrt_done = sqrt_done;
        st.out_free  = !out_valid_reg;
    end

    assign norm_valid     = out_valid_reg;
    assign mean_abs_error = out_mean_reg;
    assign rms_error      = out_rms_reg;
    assign max_abs_error  = out_max_reg;
    assign pair_count     = out_count_reg;
    assign overflow       = out_ovf_reg;
endmodule

// ===== rtl/core/ena_ctrl.sv =====
// Controller: sequences accumulation, both divides, the root and the result load.
module ena_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   last_pair,
    input  ena_pkg::ena_status_t   st,
    output logic                   ready,
    output ena_pkg::ena_cmd_t      cmd
);
    typedef enum logic [2:0] {
        S_ACCUM,
        S_DRAIN,
        S_DIV_ABS,
        S_DIV_SQ,
        S_ROOT,
        S_LOAD,
        S_REARM
    } state_t;

    state_t            state_reg;
    logic              ready_reg;
    ena_pkg::ena_cmd_t cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACCUM;
            ready_reg <= 1'b1;
            cmd_reg   <= '0;
        end
        else
        begin
            // pulse commands drop unless raised below
            cmd_reg.div_start  <= 1'b0;
            cmd_reg.sqrt_start <= 1'b0;
            cmd_reg.load       <= 1'b0;
            case (state_reg)
                S_ACCUM:
                begin
                    if (accept && last_pair)
                    begin
                        ready_reg <= 1'b0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!st.pipe_busy)
                    begin
                        cmd_reg.div_start <= 1'b1;
                        cmd_reg.div_sq    <= 1'b0;
                        state_reg         <= S_DIV_ABS;
                    end
                end
                S_DIV_ABS:
                begin
                    if (st.div_done)
                    begin
                        cmd_reg.div_start <= 1'b1;
                        cmd_reg.div_sq    <= 1'b1;
                        state_reg         <= S_DIV_SQ;
                    end
                end
                S_DIV_SQ:
                begin
                    if (st.div_done)
                    begin
                        cmd_reg.sqrt_start <= 1'b1;
                        state_reg          <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (st.sqrt_done)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (st.out_free)
                    begin
                        cmd_reg.load <= 1'b1;
                        state_reg    <= S_REARM;
                    end
                end
                S_REARM:
                begin
                    cmd_reg.div_sq <= 1'b0;
                    ready_reg      <= 1'b1;
                    state_reg      <= S_ACCUM;
                end
                default:
                begin
                    state_reg <= S_ACCUM;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign ready = ready_reg;
    assign cmd   = cmd_reg;
endmodule
